[hw/rtl/srdm_pkg.sv]
// ----------------------------------------------------------------------------
// srdm_pkg
// Shared types and constants of the split ring descriptor manager.
// ----------------------------------------------------------------------------
package srdm_pkg;

    localparam int unsigned DESC_COUNT_DEF  = 16;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam int unsigned ID_W   = 8;
    localparam int unsigned ADDR_W = 5;

    // register indexes, byte address is four times the index
    localparam logic [2:0] REG_MAX_FRAME_LEN  = 3'd0;
    localparam logic [2:0] REG_HEADER_LEN     = 3'd1;
    localparam logic [2:0] REG_BUFFER_SIZE    = 3'd2;
    localparam logic [2:0] REG_TX_BUFFER_BASE = 3'd3;
    localparam logic [2:0] REG_RX_BUFFER_BASE = 3'd4;

    localparam logic [15:0] MAX_FRAME_LEN_RST = 16'd1514;
    localparam logic [6:0]  HEADER_LEN_RST    = 7'd12;
    localparam logic [15:0] BUFFER_SIZE_RST   = 16'd2048;

    typedef enum logic [1:0] {
        ACT_SEND    = 2'd0,
        ACT_TX_USED = 2'd1,
        ACT_RX_USED = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEN  = 2'd1,
        ST_NO_DESC  = 2'd2,
        ST_BAD_USED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        NTF_NONE = 2'd0,
        NTF_RX   = 2'd1,
        NTF_TX   = 2'd2
    } t_notify;

    typedef enum logic [2:0] {
        K_SEND,
        K_SEND_BAD,
        K_TX_USED,
        K_RX_USED,
        K_RX_NOCAP,
        K_BAD_ACT
    } t_kind;

    typedef struct packed {
        logic [15:0] max_frame_len;
        logic [6:0]  header_len;
        logic [15:0] buffer_size;
        logic [31:0] tx_buffer_base;
        logic [31:0] rx_buffer_base;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [ID_W-1:0] id;
        logic        id_ok;
        logic        rx_short;
        logic [15:0] desc_len;
        logic [15:0] clip_len;
    } t_cmd;

    // executed item waiting for its buffer address
    typedef struct packed {
        t_status     status;
        logic [7:0]  desc_index;
        logic [7:0]  ring_slot;
        logic [15:0] avail_index;
        logic [15:0] desc_length;
        logic        desc_writable;
        logic        addr_en;
        logic        addr_rx;
        logic [15:0] copy_length;
        t_notify     notify_sel;
        logic [7:0]  used_slot;
    } t_exec;

endpackage

[hw/rtl/srdm_cfg.sv]
// ----------------------------------------------------------------------------
// srdm_cfg
// Configuration registers behind an APB-style slave port.
// ----------------------------------------------------------------------------
module srdm_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srdm_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output srdm_pkg::t_cfg                o_cfg
);

    srdm_pkg::t_cfg r_cfg;
    srdm_pkg::t_cfg n_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[srdm_pkg::ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                srdm_pkg::REG_MAX_FRAME_LEN:  n_cfg.max_frame_len  = pwdata[15:0];
                srdm_pkg::REG_HEADER_LEN:     n_cfg.header_len     = pwdata[6:0];
                srdm_pkg::REG_BUFFER_SIZE:    n_cfg.buffer_size    = pwdata[15:0];
                srdm_pkg::REG_TX_BUFFER_BASE: n_cfg.tx_buffer_base = pwdata;
                srdm_pkg::REG_RX_BUFFER_BASE: n_cfg.rx_buffer_base = pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            srdm_pkg::REG_MAX_FRAME_LEN:  prdata = {16'd0, r_cfg.max_frame_len};
            srdm_pkg::REG_HEADER_LEN:     prdata = {25'd0, r_cfg.header_len};
            srdm_pkg::REG_BUFFER_SIZE:    prdata = {16'd0, r_cfg.buffer_size};
            srdm_pkg::REG_TX_BUFFER_BASE: prdata = r_cfg.tx_buffer_base;
            srdm_pkg::REG_RX_BUFFER_BASE: prdata = r_cfg.rx_buffer_base;
            default:                      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_frame_len  <= srdm_pkg::MAX_FRAME_LEN_RST;
            r_cfg.header_len     <= srdm_pkg::HEADER_LEN_RST;
            r_cfg.buffer_size    <= srdm_pkg::BUFFER_SIZE_RST;
            r_cfg.tx_buffer_base <= 32'd0;
            r_cfg.rx_buffer_base <= 32'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/srdm_front.sv]
// ----------------------------------------------------------------------------
// srdm_front
// Takes items in, checks lengths and ids and classifies each for the back end.
// ----------------------------------------------------------------------------
module srdm_front #(
    parameter int unsigned DESC_COUNT = srdm_pkg::DESC_COUNT_DEF
) (
    input  logic            i_start,
    input  logic [1:0]      i_action,
    input  logic [15:0]     i_length,
    input  logic [15:0]     i_used_desc_id,
    input  logic [15:0]     i_used_length,
    input  srdm_pkg::t_cfg  i_cfg,
    input  logic            i_q_full,
    output logic            o_busy,
    output logic            o_push,
    output srdm_pkg::t_cmd  o_cmd
);

    logic [16:0] total;
    logic        send_bad;
    logic        rx_short;
    logic [15:0] hdr;
    logic [15:0] payload_len;

    assign hdr      = 16'(i_cfg.header_len);
    assign total    = {1'b0, i_length} + {1'b0, hdr};
    // the sum overflowing 16 bits is caught by the buffer size check
    assign send_bad = (i_length == 16'd0) || (i_length > i_cfg.max_frame_len)
                      || (total > {1'b0, i_cfg.buffer_size});
    assign rx_short = (i_used_length <= hdr);
    assign payload_len = i_used_length - hdr;

    assign o_busy = i_q_full;
    assign o_push = i_start & ~i_q_full;

    always_comb begin
        o_cmd          = '0;
        o_cmd.id       = i_used_desc_id[srdm_pkg::ID_W-1:0];
        o_cmd.id_ok    = (i_used_desc_id < 16'(DESC_COUNT));
        o_cmd.rx_short = rx_short;
        o_cmd.desc_len = total[15:0];
        o_cmd.clip_len = (payload_len > i_length) ? i_length : payload_len;
        case (srdm_pkg::t_action'(i_action))
            srdm_pkg::ACT_SEND:    o_cmd.kind = send_bad ? srdm_pkg::K_SEND_BAD
                                                         : srdm_pkg::K_SEND;
            srdm_pkg::ACT_TX_USED: o_cmd.kind = srdm_pkg::K_TX_USED;
            srdm_pkg::ACT_RX_USED: o_cmd.kind = (i_length == 16'd0) ? srdm_pkg::K_RX_NOCAP
                                                                  : srdm_pkg::K_RX_USED;
            default:               o_cmd.kind = srdm_pkg::K_BAD_ACT;
        endcase
    end

endmodule

[hw/rtl/srdm_queue.sv]
// ----------------------------------------------------------------------------
// srdm_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module srdm_queue #(
    parameter int unsigned DEPTH = srdm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  srdm_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output srdm_pkg::t_cmd  o_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    srdm_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[hw/rtl/srdm_back.sv]
// ----------------------------------------------------------------------------
// srdm_back
// Carries out items: ring state update, then buffer address and result.
// ----------------------------------------------------------------------------
module srdm_back #(
    parameter int unsigned DESC_COUNT = srdm_pkg::DESC_COUNT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  srdm_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  srdm_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    output logic [1:0]      o_status,
    output logic [7:0]      o_desc_index,
    output logic [7:0]      o_ring_slot,
    output logic [15:0]     o_avail_index,
    output logic [15:0]     o_desc_length,
    output logic            o_desc_writable,
    output logic [31:0]     o_buffer_address,
    output logic [15:0]     o_copy_length,
    output logic [1:0]      o_notify_queue,
    output logic [7:0]      o_used_slot
);

    localparam int unsigned SLOT_W = $clog2(DESC_COUNT);

    logic [DESC_COUNT-1:0] r_free_map, n_free_map;
    logic [15:0]           r_tx_avail, n_tx_avail;
    logic [15:0]           r_rx_avail, n_rx_avail;
    logic [15:0]           r_tx_used, n_tx_used;
    logic [15:0]           r_rx_used, n_rx_used;
    logic [SLOT_W-1:0]     r_tx_avail_slot, n_tx_avail_slot;
    logic [SLOT_W-1:0]     r_rx_avail_slot, n_rx_avail_slot;
    logic [SLOT_W-1:0]     r_tx_used_slot, n_tx_used_slot;
    logic [SLOT_W-1:0]     r_rx_used_slot, n_rx_used_slot;

    logic                  r_exec_valid;
    srdm_pkg::t_exec       r_exec, n_exec;

    logic                  r_out_valid;
    srdm_pkg::t_exec       r_out;
    logic [31:0]           r_out_addr, n_out_addr;

    logic [SLOT_W-1:0]     pick;
    logic                  pick_found;
    logic [SLOT_W-1:0]     id_idx;
    logic [23:0]           offset;
    logic [31:0]           base;

    assign o_pop  = i_valid;
    assign id_idx = i_cmd.id[SLOT_W-1:0];

    // lowest free transmit descriptor
    always_comb begin
        pick       = '0;
        pick_found = 1'b0;
        for (int i = DESC_COUNT - 1; i >= 0; i--) begin
            if (r_free_map[i]) begin
                pick       = SLOT_W'(i);
                pick_found = 1'b1;
            end
        end
    end

    // slots follow count mod descriptor count, also across the 16 bit wrap
    function automatic logic [SLOT_W-1:0] slot_next(input logic [15:0] cnt,
                                                   input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] res;
        if (cnt == 16'hFFFF || slot == SLOT_W'(DESC_COUNT - 1)) begin
            res = '0;
        end else begin
            res = slot + 1'b1;
        end
        return res;
    endfunction

    always_comb begin
        n_free_map      = r_free_map;
        n_tx_avail      = r_tx_avail;
        n_rx_avail      = r_rx_avail;
        n_tx_used       = r_tx_used;
        n_rx_used       = r_rx_used;
        n_tx_avail_slot = r_tx_avail_slot;
        n_rx_avail_slot = r_rx_avail_slot;
        n_tx_used_slot  = r_tx_used_slot;
        n_rx_used_slot  = r_rx_used_slot;
        n_exec          = '0;
        n_exec.status     = srdm_pkg::ST_OK;
        n_exec.notify_sel = srdm_pkg::NTF_NONE;
        if (i_valid) begin
            case (i_cmd.kind)
                srdm_pkg::K_SEND: begin
                    if (!pick_found) begin
                        n_exec.status = srdm_pkg::ST_NO_DESC;
                    end else begin
                        n_free_map[pick]     = 1'b0;
                        n_exec.desc_index    = 8'(pick);
                        n_exec.ring_slot     = 8'(r_tx_avail_slot);
                        n_tx_avail           = r_tx_avail + 16'd1;
                        n_tx_avail_slot      = slot_next(r_tx_avail, r_tx_avail_slot);
                        n_exec.avail_index   = n_tx_avail;
                        n_exec.desc_length   = i_cmd.desc_len;
                        n_exec.addr_en       = 1'b1;
                        n_exec.notify_sel    = srdm_pkg::NTF_TX;
                    end
                end
                srdm_pkg::K_TX_USED: begin
                    n_exec.used_slot = 8'(r_tx_used_slot);
                    n_tx_used        = r_tx_used + 16'd1;
                    n_tx_used_slot   = slot_next(r_tx_used, r_tx_used_slot);
                    if (i_cmd.id_ok) begin
                        n_free_map[id_idx] = 1'b1;
                        n_exec.desc_index  = i_cmd.id;
                    end else begin
                        n_exec.status = srdm_pkg::ST_BAD_USED;
                    end
                end
                srdm_pkg::K_RX_USED: begin
                    n_exec.used_slot = 8'(r_rx_used_slot);
                    n_rx_used        = r_rx_used + 16'd1;
                    n_rx_used_slot   = slot_next(r_rx_used, r_rx_used_slot);
                    if (!i_cmd.id_ok) begin
                        n_exec.status = srdm_pkg::ST_BAD_USED;
                    end else begin
                        // short data still reposts the buffer
                        if (i_cmd.rx_short) begin
                            n_exec.status = srdm_pkg::ST_BAD_USED;
                        end else begin
                            n_exec.copy_length = i_cmd.clip_len;
                        end
                        n_exec.desc_index    = i_cmd.id;
                        n_exec.ring_slot     = 8'(r_rx_avail_slot);
                        n_rx_avail           = r_rx_avail + 16'd1;
                        n_rx_avail_slot      = slot_next(r_rx_avail, r_rx_avail_slot);
                        n_exec.avail_index   = n_rx_avail;
                        n_exec.desc_length   = i_cfg.buffer_size;
                        n_exec.desc_writable = 1'b1;
                        n_exec.addr_en       = 1'b1;
                        n_exec.addr_rx       = 1'b1;
                        n_exec.notify_sel    = srdm_pkg::NTF_RX;
                    end
                end
                srdm_pkg::K_SEND_BAD,
                srdm_pkg::K_RX_NOCAP: n_exec.status = srdm_pkg::ST_BAD_LEN;
                default:              n_exec.status = srdm_pkg::ST_BAD_USED;
            endcase
        end
    end

    // second stage: base plus index times buffer size
    assign offset = r_exec.desc_index * i_cfg.buffer_size;
    assign base   = r_exec.addr_rx ? i_cfg.rx_buffer_base : i_cfg.tx_buffer_base;
    assign n_out_addr = r_exec.addr_en ? (base + 32'(offset)) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_map      <= '1;
            r_tx_avail      <= 16'd0;
            r_rx_avail      <= 16'(DESC_COUNT);
            r_tx_used       <= 16'd0;
            r_rx_used       <= 16'd0;
            r_tx_avail_slot <= '0;
            r_rx_avail_slot <= '0;
            r_tx_used_slot  <= '0;
            r_rx_used_slot  <= '0;
            r_exec_valid    <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_free_map      <= n_free_map;
            r_tx_avail      <= n_tx_avail;
            r_rx_avail      <= n_rx_avail;
            r_tx_used       <= n_tx_used;
            r_rx_used       <= n_rx_used;
            r_tx_avail_slot <= n_tx_avail_slot;
            r_rx_avail_slot <= n_rx_avail_slot;
            r_tx_used_slot  <= n_tx_used_slot;
            r_rx_used_slot  <= n_rx_used_slot;
            r_exec_valid    <= i_valid;
            r_out_valid     <= r_exec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exec     <= n_exec;
        r_out      <= r_exec;
        r_out_addr <= n_out_addr;
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_desc_index     = r_out.desc_index;
    assign o_ring_slot      = r_out.ring_slot;
    assign o_avail_index    = r_out.avail_index;
    assign o_desc_length    = r_out.desc_length;
    assign o_desc_writable  = r_out.desc_writable;
    assign o_buffer_address = r_out_addr;
    assign o_copy_length    = r_out.copy_length;
    assign o_notify_queue   = r_out.notify_sel;
    assign o_used_slot      = r_out.used_slot;

endmodule

[hw/rtl/split_ring_descriptor_manager_top.sv]
// ----------------------------------------------------------------------------
// split_ring_descriptor_manager_top
// Driver-side descriptor manager for one transmit and one receive split ring.
// ----------------------------------------------------------------------------
// One item (send, transmit completion or receive completion) is taken per
// clock while busy is low and gives exactly one result, shown for a single
// cycle with o_valid after the queue entry and the execute and output stages;
// the receiver cannot stall it. The back end retires one item every cycle, so
// the two-entry queue behind the classifier never fills and busy stays low in
// normal use. The lowest free transmit descriptor comes from a priority
// encoder over the free map, and the buffer address multiply has a pipeline
// stage of its own. Transmit completions must be presented before the sends
// that depend on them. Registers sit at byte addresses 0x00 to 0x10 and should
// be written only while no item is in flight.
module split_ring_descriptor_manager_top #(
    parameter int unsigned DESC_COUNT  = srdm_pkg::DESC_COUNT_DEF,
    parameter int unsigned QUEUE_DEPTH = srdm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srdm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [1:0]                  i_action,
    input  logic [15:0]                 i_length,
    input  logic [15:0]                 i_used_desc_id,
    input  logic [15:0]                 i_used_length,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic [7:0]                  o_desc_index,
    output logic [7:0]                  o_ring_slot,
    output logic [15:0]                 o_avail_index,
    output logic [15:0]                 o_desc_length,
    output logic                        o_desc_writable,
    output logic [31:0]                 o_buffer_address,
    output logic [15:0]                 o_copy_length,
    output logic [1:0]                  o_notify_queue,
    output logic [7:0]                  o_used_slot
);

    srdm_pkg::t_cfg cfg;
    srdm_pkg::t_cmd front_cmd;
    srdm_pkg::t_cmd queue_cmd;
    logic           push;
    logic           pop;
    logic           q_valid;
    logic           q_full;

    srdm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    srdm_front #(
        .DESC_COUNT (DESC_COUNT)
    ) u_front (
        .i_start        (i_start),
        .i_action       (i_action),
        .i_length       (i_length),
        .i_used_desc_id (i_used_desc_id),
        .i_used_length  (i_used_length),
        .i_cfg          (cfg),
        .i_q_full       (q_full),
        .o_busy         (o_busy),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    srdm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (queue_cmd)
    );

    srdm_back #(
        .DESC_COUNT (DESC_COUNT)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (q_valid),
        .i_cmd            (queue_cmd),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_desc_index     (o_desc_index),
        .o_ring_slot      (o_ring_slot),
        .o_avail_index    (o_avail_index),
        .o_desc_length    (o_desc_length),
        .o_desc_writable  (o_desc_writable),
        .o_buffer_address (o_buffer_address),
        .o_copy_length    (o_copy_length),
        .o_notify_queue   (o_notify_queue),
        .o_used_slot      (o_used_slot)
    );

endmodule

[sim/split_ring_descriptor_manager_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// split_ring_descriptor_manager_top_tb
// Self-checking bench for the split ring descriptor manager. A queue of
// send, transmit completion and receive completion items feeds a clocked
// driver. Each accepted item runs through a ring-state predictor, and a
// clocked monitor compares every result strobe with the oldest prediction.
// Register settings change between traffic bursts, including the extremes.
// ----------------------------------------------------------------------------
module split_ring_descriptor_manager_top_tb;

    localparam int unsigned DESC_COUNT   = srdm_pkg::DESC_COUNT_DEF;
    localparam int unsigned QUIET_LIMIT  = 5000;
    localparam int unsigned REPORT_MAX   = 10;
    localparam logic [1:0]  ACT_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] length;
        logic [15:0] used_desc_id;
        logic [15:0] used_length;
    } t_ring_item;

    typedef struct packed {
        srdm_pkg::t_status status;
        logic [7:0]        desc_index;
        logic [7:0]        ring_slot;
        logic [15:0]       avail_index;
        logic [15:0]       desc_length;
        logic              desc_writable;
        logic [31:0]       buffer_address;
        logic [15:0]       copy_length;
        srdm_pkg::t_notify notify_sel;
        logic [7:0]        used_slot;
    } t_ring_result;

    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        psel            = 1'b0;
    logic                        penable         = 1'b0;
    logic                        pwrite          = 1'b0;
    logic [srdm_pkg::ADDR_W-1:0] paddr           = '0;
    logic [31:0]                 pwdata          = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        i_start         = 1'b0;
    logic                        o_busy;
    logic [1:0]                  i_action        = '0;
    logic [15:0]                 i_length        = '0;
    logic [15:0]                 i_used_desc_id  = '0;
    logic [15:0]                 i_used_length   = '0;
    logic                        o_valid;
    logic [1:0]                  o_status;
    logic [7:0]                  o_desc_index;
    logic [7:0]                  o_ring_slot;
    logic [15:0]                 o_avail_index;
    logic [15:0]                 o_desc_length;
    logic                        o_desc_writable;
    logic [31:0]                 o_buffer_address;
    logic [15:0]                 o_copy_length;
    logic [1:0]                  o_notify_queue;
    logic [7:0]                  o_used_slot;

    // predictor copy of the registers and ring state
    srdm_pkg::t_cfg ring_cfg = '{max_frame_len: srdm_pkg::MAX_FRAME_LEN_RST,
                                 header_len: srdm_pkg::HEADER_LEN_RST,
                                 buffer_size: srdm_pkg::BUFFER_SIZE_RST,
                                 tx_buffer_base: '0,
                                 rx_buffer_base: '0};
    logic [DESC_COUNT-1:0] tx_free_bits;
    logic [15:0]           tx_avail_idx;
    logic [15:0]           rx_avail_idx;
    logic [15:0]           tx_done_cnt;
    logic [15:0]           rx_done_cnt;

    // transmit descriptors the stimulus believes are in flight
    logic [DESC_COUNT-1:0] stim_claimed = '0;

    t_ring_item   pending_actions[$];
    t_ring_result expected_completions[$];
    int unsigned  sender_idle_pct = 0;
    int unsigned  mismatch_count  = 0;
    int unsigned  quiet_cycles    = 0;

    split_ring_descriptor_manager_top #(
        .DESC_COUNT (DESC_COUNT)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_action         (i_action),
        .i_length         (i_length),
        .i_used_desc_id   (i_used_desc_id),
        .i_used_length    (i_used_length),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_desc_index     (o_desc_index),
        .o_ring_slot      (o_ring_slot),
        .o_avail_index    (o_avail_index),
        .o_desc_length    (o_desc_length),
        .o_desc_writable  (o_desc_writable),
        .o_buffer_address (o_buffer_address),
        .o_copy_length    (o_copy_length),
        .o_notify_queue   (o_notify_queue),
        .o_used_slot      (o_used_slot)
    );

    initial begin : clock_gen
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] buffer_addr(input logic [31:0] base,
                                                input int unsigned idx);
        return base + 32'(idx) * 32'(ring_cfg.buffer_size);
    endfunction

    function automatic t_ring_result predict_ring_update(input t_ring_item it);
        t_ring_result r;
        logic [16:0]  total;
        logic [15:0]  data;
        int           pick;
        r = '0;
        case (it.action)
            srdm_pkg::ACT_SEND: begin
                total = 17'(it.length) + 17'(ring_cfg.header_len);
                pick  = -1;
                if (it.length == 0 || it.length > ring_cfg.max_frame_len ||
                    total > 17'h0FFFF || total > 17'(ring_cfg.buffer_size)) begin
                    r.status = srdm_pkg::ST_BAD_LEN;
                end else begin
                    for (int i = DESC_COUNT - 1; i >= 0; i--) begin
                        if (tx_free_bits[i]) pick = i;
                    end
                    if (pick < 0) begin
                        r.status = srdm_pkg::ST_NO_DESC;
                    end else begin
                        tx_free_bits[pick] = 1'b0;
                        r.desc_index       = 8'(pick);
                        r.ring_slot        = 8'(tx_avail_idx % DESC_COUNT);
                        tx_avail_idx       = tx_avail_idx + 16'd1;
                        r.avail_index      = tx_avail_idx;
                        r.desc_length      = total[15:0];
                        r.buffer_address   = buffer_addr(ring_cfg.tx_buffer_base, pick);
                        r.notify_sel       = srdm_pkg::NTF_TX;
                    end
                end
            end
            srdm_pkg::ACT_TX_USED: begin
                r.used_slot = 8'(tx_done_cnt % DESC_COUNT);
                tx_done_cnt = tx_done_cnt + 16'd1;
                if (it.used_desc_id < DESC_COUNT) begin
                    tx_free_bits[it.used_desc_id] = 1'b1;
                    r.desc_index = it.used_desc_id[7:0];
                end else begin
                    r.status = srdm_pkg::ST_BAD_USED;
                end
            end
            srdm_pkg::ACT_RX_USED: begin
                if (it.length == 0) begin
                    r.status = srdm_pkg::ST_BAD_LEN;
                end else begin
                    r.used_slot = 8'(rx_done_cnt % DESC_COUNT);
                    rx_done_cnt = rx_done_cnt + 16'd1;
                    if (it.used_desc_id >= DESC_COUNT) begin
                        r.status = srdm_pkg::ST_BAD_USED;
                    end else begin
                        if (it.used_length <= ring_cfg.header_len) begin
                            r.status = srdm_pkg::ST_BAD_USED;
                        end else begin
                            data = it.used_length - 16'(ring_cfg.header_len);
                            r.copy_length = (data > it.length) ? it.length : data;
                        end
                        // short or not, the buffer goes straight back on the ring
                        r.desc_index     = it.used_desc_id[7:0];
                        r.ring_slot      = 8'(rx_avail_idx % DESC_COUNT);
                        rx_avail_idx     = rx_avail_idx + 16'd1;
                        r.avail_index    = rx_avail_idx;
                        r.desc_length    = ring_cfg.buffer_size;
                        r.desc_writable  = 1'b1;
                        r.buffer_address = buffer_addr(ring_cfg.rx_buffer_base,
                                                       it.used_desc_id);
                        r.notify_sel     = srdm_pkg::NTF_RX;
                    end
                end
            end
            default: r.status = srdm_pkg::ST_BAD_USED;
        endcase
        return r;
    endfunction

    function automatic string describe_result(input t_ring_result r);
        return $sformatf({"status=%0d desc=%0d slot=%0d avail=%0d dlen=%0d wr=%0b",
                          " addr=%h copy=%0d notify=%0d used=%0d"},
                         r.status, r.desc_index, r.ring_slot, r.avail_index,
                         r.desc_length, r.desc_writable, r.buffer_address,
                         r.copy_length, r.notify_sel, r.used_slot);
    endfunction

    // longest send frame that the current setup accepts
    function automatic int send_limit();
        int lim;
        lim = int'(ring_cfg.max_frame_len);
        if (int'(ring_cfg.buffer_size) - int'(ring_cfg.header_len) < lim)
            lim = int'(ring_cfg.buffer_size) - int'(ring_cfg.header_len);
        return lim;
    endfunction

    function automatic void queue_action(input logic [1:0] act, input logic [15:0] len,
                                         input logic [15:0] id, input logic [15:0] ulen);
        t_ring_item it;
        logic       done;
        it   = '{act, len, id, ulen};
        done = 1'b0;
        if (act == srdm_pkg::ACT_SEND && len >= 1 && int'(len) <= send_limit()) begin
            for (int i = 0; i < DESC_COUNT; i++) begin
                if (!stim_claimed[i] && !done) begin
                    stim_claimed[i] = 1'b1;
                    done            = 1'b1;
                end
            end
        end else if (act == srdm_pkg::ACT_TX_USED && id < DESC_COUNT) begin
            stim_claimed[id] = 1'b0;
        end
        pending_actions.push_back(it);
    endfunction

    function automatic void queue_random_action();
        int unsigned roll;
        int          lim;
        logic [1:0]  act;
        logic [15:0] len;
        logic [15:0] id;
        logic [15:0] ulen;
        len  = 16'($urandom);
        id   = 16'($urandom);
        ulen = 16'($urandom);
        lim  = send_limit();
        roll = $urandom_range(99);
        if (roll < 36) begin
            act = srdm_pkg::ACT_SEND;
            if ($urandom_range(9) != 0 && lim >= 1) begin
                if ($urandom_range(3) == 0)
                    len = 16'($urandom_range((lim < 64) ? lim : 64, 1));
                else
                    len = 16'($urandom_range(lim, 1));
            end else begin
                case ($urandom_range(2))
                    0:       len = '0;
                    1:       len = 16'(lim + 1);
                    default: ;
                endcase
            end
        end else if (roll < 66) begin
            act = srdm_pkg::ACT_TX_USED;
            // mostly complete a descriptor that is really out with the device
            if ($urandom_range(19) != 0) begin
                id = 16'($urandom_range(DESC_COUNT - 1));
                if (stim_claimed != '0) begin
                    while (!stim_claimed[id]) id = 16'($urandom_range(DESC_COUNT - 1));
                end
            end
        end else if (roll < 96) begin
            act = srdm_pkg::ACT_RX_USED;
            case ($urandom_range(19))
                0:                len = '0;
                1, 2, 3, 4, 5, 6: len = 16'($urandom_range(64, 1));
                default:          len = 16'($urandom_range(65535, 1));
            endcase
            if ($urandom_range(19) != 0) id = 16'($urandom_range(DESC_COUNT - 1));
            case ($urandom_range(7))
                0:       ulen = 16'($urandom_range(ring_cfg.header_len));
                1:       ;
                default: ulen = 16'($urandom_range(ring_cfg.buffer_size,
                                                   ring_cfg.header_len + 1));
            endcase
        end else begin
            act = ACT_RESERVED;
        end
        queue_action(act, len, id, ulen);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            srdm_pkg::REG_MAX_FRAME_LEN:  ring_cfg.max_frame_len  = value[15:0];
            srdm_pkg::REG_HEADER_LEN:     ring_cfg.header_len     = value[6:0];
            srdm_pkg::REG_BUFFER_SIZE:    ring_cfg.buffer_size    = value[15:0];
            srdm_pkg::REG_TX_BUFFER_BASE: ring_cfg.tx_buffer_base = value;
            srdm_pkg::REG_RX_BUFFER_BASE: ring_cfg.rx_buffer_base = value;
            default: ;
        endcase
    endtask

    task automatic apply_setup(input logic [15:0] max_len, input logic [6:0] hdr,
                               input logic [15:0] bsize, input logic [31:0] tx_base,
                               input logic [31:0] rx_base);
        write_reg(srdm_pkg::REG_MAX_FRAME_LEN, 32'(max_len));
        write_reg(srdm_pkg::REG_HEADER_LEN, 32'(hdr));
        write_reg(srdm_pkg::REG_BUFFER_SIZE, 32'(bsize));
        write_reg(srdm_pkg::REG_TX_BUFFER_BASE, tx_base);
        write_reg(srdm_pkg::REG_RX_BUFFER_BASE, rx_base);
        @(negedge i_clk);
    endtask

    // checked on the falling edge so the driver's queue pops have settled
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_actions.size() != 0 || i_start || expected_completions.size() != 0);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_traffic(input int unsigned count, input int unsigned idle_pct);
        sender_idle_pct = idle_pct;
        repeat (count) queue_random_action();
        wait_drained();
    endtask

    always @(posedge i_clk) begin : drive_actions
        t_ring_item next_item;
        if (!i_rst_n) begin
            i_start      <= 1'b0;
            tx_free_bits = '1;
            tx_avail_idx = '0;
            rx_avail_idx = 16'(DESC_COUNT);
            tx_done_cnt  = '0;
            rx_done_cnt  = '0;
        end else begin
            if (i_start && !o_busy)
                expected_completions.push_back(predict_ring_update(
                    '{i_action, i_length, i_used_desc_id, i_used_length}));
            if (!(i_start && o_busy)) begin
                if (pending_actions.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_item      = pending_actions.pop_front();
                    i_start        <= 1'b1;
                    i_action       <= next_item.action;
                    i_length       <= next_item.length;
                    i_used_desc_id <= next_item.used_desc_id;
                    i_used_length  <= next_item.used_length;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_ring_result seen;
        t_ring_result want;
        if (i_rst_n && o_valid) begin
            seen = '{srdm_pkg::t_status'(o_status), o_desc_index, o_ring_slot,
                     o_avail_index, o_desc_length, o_desc_writable, o_buffer_address,
                     o_copy_length, srdm_pkg::t_notify'(o_notify_queue), o_used_slot};
            if (expected_completions.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: %s", describe_result(seen));
            end else begin
                want = expected_completions.pop_front();
                if (seen !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("result mismatch, expected %s", describe_result(want));
                        $display("                 actual   %s", describe_result(seen));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_start && !o_busy) || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("split_ring_descriptor_manager_top test failed");
            $finish;
        end
    end

    initial begin : run_sequence
        int unsigned mode;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setup: bad lengths, fill every transmit descriptor, then overrun
        queue_action(srdm_pkg::ACT_SEND, 16'd0, 16'd0, 16'd0);
        queue_action(srdm_pkg::ACT_SEND, 16'd1515, 16'd0, 16'd0);
        queue_action(srdm_pkg::ACT_SEND, 16'd1514, 16'd0, 16'd0);
        repeat (DESC_COUNT - 1) queue_action(srdm_pkg::ACT_SEND, 16'd1, 16'd0, 16'd0);
        queue_action(srdm_pkg::ACT_SEND, 16'd100, 16'd0, 16'd0);
        queue_action(srdm_pkg::ACT_TX_USED, 16'd0, 16'd3, 16'd0);
        // freeing it twice leaves it free
        queue_action(srdm_pkg::ACT_TX_USED, 16'd0, 16'd3, 16'd0);
        queue_action(srdm_pkg::ACT_TX_USED, 16'd0, 16'(DESC_COUNT), 16'd0);
        queue_action(srdm_pkg::ACT_TX_USED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_action(srdm_pkg::ACT_SEND, 16'd64, 16'd0, 16'd0);
        queue_action(srdm_pkg::ACT_RX_USED, 16'd0, 16'd1, 16'd100);
        queue_action(srdm_pkg::ACT_RX_USED, 16'd100, 16'hFFFF, 16'd100);
        queue_action(srdm_pkg::ACT_RX_USED, 16'd100, 16'd0, 16'(srdm_pkg::HEADER_LEN_RST));
        queue_action(srdm_pkg::ACT_RX_USED, 16'hFFFF, 16'(DESC_COUNT - 1), 16'hFFFF);
        queue_action(srdm_pkg::ACT_RX_USED, 16'd10, 16'd5, 16'd1000);
        queue_action(ACT_RESERVED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_traffic(150, 0);

        // widest setup: length plus header overflowing 16 bits, wrapping addresses
        apply_setup(16'hFFFF, 7'd64, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_0000);
        queue_action(srdm_pkg::ACT_TX_USED, 16'd0, 16'd0, 16'd0);
        queue_action(srdm_pkg::ACT_SEND, 16'd65472, 16'd0, 16'd0);
        queue_action(srdm_pkg::ACT_SEND, 16'd65471, 16'd0, 16'd0);
        queue_action(srdm_pkg::ACT_RX_USED, 16'hFFFF, 16'd2, 16'd64);
        queue_action(srdm_pkg::ACT_RX_USED, 16'hFFFF, 16'd2, 16'd65);
        run_traffic(150, 80);

        // narrowest setup: one byte frames, no header, smallest buffers
        apply_setup(16'd1, 7'd0, 16'd64, $urandom, $urandom);
        queue_action(srdm_pkg::ACT_TX_USED, 16'd0, 16'd1, 16'd0);
        queue_action(srdm_pkg::ACT_SEND, 16'd1, 16'd0, 16'd0);
        queue_action(srdm_pkg::ACT_SEND, 16'd2, 16'd0, 16'd0);
        queue_action(srdm_pkg::ACT_RX_USED, 16'd1, 16'd4, 16'd0);
        queue_action(srdm_pkg::ACT_RX_USED, 16'd1, 16'd4, 16'd1);
        run_traffic(120, 13);

        // header nearly fills the buffer
        apply_setup(16'hFFFF, 7'd63, 16'd64, $urandom, $urandom);
        queue_action(srdm_pkg::ACT_TX_USED, 16'd0, 16'd2, 16'd0);
        queue_action(srdm_pkg::ACT_SEND, 16'd1, 16'd0, 16'd0);
        queue_action(srdm_pkg::ACT_SEND, 16'd2, 16'd0, 16'd0);
        run_traffic(60, 0);
        run_traffic(60, 80);

        repeat (3) begin
            apply_setup(16'($urandom_range(65535, 1)), 7'($urandom_range(64)),
                        16'($urandom_range(65535, 64)), $urandom, $urandom);
            mode = $urandom_range(2);
            run_traffic(70, (mode == 0) ? 0 : ((mode == 1) ? 80 : 13));
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_completions.size() == 0) begin
            $display("split_ring_descriptor_manager_top test passed");
        end else begin
            $display("split_ring_descriptor_manager_top test failed");
        end
        $finish;
    end

endmodule
